// ===== src/escape_sequence_to_utf8_top_assert.svh =====
// assertion macros for the escape sequence to utf-8 decoder
// used by the port checker; needs nothing else
`ifndef ESCAPE_SEQUENCE_TO_UTF8_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_TO_UTF8_TOP_ASSERT_SVH

// property checked on every clock edge outside reset
`define ESU8_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must also hold through reset
`define ESU8_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/esu8_pkg.sv =====
// shared types, character codes and decode helpers for the escape decoder
// no dependencies
package esu8_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_A         = 8'h61;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_V         = 8'h76;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CODE_BEL       = 8'h07;
   localparam logic [7:0] CODE_BS        = 8'h08;
   localparam logic [7:0] CODE_FF        = 8'h0C;
   localparam logic [7:0] CODE_LF        = 8'h0A;
   localparam logic [7:0] CODE_CR        = 8'h0D;
   localparam logic [7:0] CODE_TAB       = 8'h09;
   localparam logic [7:0] CODE_VT        = 8'h0B;
   localparam logic [7:0] CODE_NUL       = 8'h00;

   localparam logic [2:0] DIGITS_X = 3'd2;
   localparam logic [2:0] DIGITS_U = 3'd4;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX   = 2'd2,
      MODE_DROP  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       literal_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       bad_escape;
   } rsp_type;

   // up to three result bytes from one input byte
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            last;
      logic            bad;
   } record_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            hex_digit = {1'b1, d[3:0]};
         end else if (c >= CHAR_A && c <= CHAR_F) begin
            d = c - CHAR_A + 8'd10;
            hex_digit = {1'b1, d[3:0]};
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            d = c - CHAR_UPPER_A + 8'd10;
            hex_digit = {1'b1, d[3:0]};
         end else begin
            hex_digit = {1'b0, d[3:0]};
         end
      end
   endfunction

   // {valid, byte}
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      begin
         case (c)
            CHAR_BACKSLASH: simple_escape = {1'b1, CHAR_BACKSLASH};
            CHAR_QUOTE:     simple_escape = {1'b1, CHAR_QUOTE};
            CHAR_DQUOTE:    simple_escape = {1'b1, CHAR_DQUOTE};
            CHAR_A:         simple_escape = {1'b1, CODE_BEL};
            CHAR_B:         simple_escape = {1'b1, CODE_BS};
            CHAR_F:         simple_escape = {1'b1, CODE_FF};
            CHAR_N:         simple_escape = {1'b1, CODE_LF};
            CHAR_R:         simple_escape = {1'b1, CODE_CR};
            CHAR_T:         simple_escape = {1'b1, CODE_TAB};
            CHAR_V:         simple_escape = {1'b1, CODE_VT};
            CHAR_ZERO:      simple_escape = {1'b1, CODE_NUL};
            default:        simple_escape = {1'b0, CODE_NUL};
         endcase
      end
   endfunction

   function automatic record_type single_rec(input logic [7:0] b, input logic last);
      record_type r;
      begin
         r = '0;
         r.count    = 2'd1;
         r.bytes[0] = b;
         r.last     = last;
         single_rec = r;
      end
   endfunction

   function automatic record_type error_rec();
      record_type r;
      begin
         r = '0;
         r.count = 2'd1;
         r.last  = 1'b1;
         r.bad   = 1'b1;
         error_rec = r;
      end
   endfunction

   function automatic record_type utf8_rec(input logic [15:0] cp, input logic last);
      record_type r;
      begin
         r = '0;
         r.last = last;
         if (cp <= 16'h007F) begin
            r.count    = 2'd1;
            r.bytes[0] = cp[7:0];
         end else if (cp <= 16'h07FF) begin
            r.count    = 2'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
         end else begin
            r.count    = 2'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
         end
         utf8_rec = r;
      end
   endfunction

endpackage

// ===== src/esu8_front.sv =====
// front end: escape state machine, one input byte per cycle while accept is high, builds result records
// depends on esu8_pkg
module esu8_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  esu8_pkg::req_type    req_data,
   output logic                 rec_valid,
   output esu8_pkg::record_type rec
);
   import esu8_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [2:0]  digits_ff, digits_in;
   logic [15:0] accum_ff, accum_in;

   logic [7:0]  c;
   logic        last;
   logic [4:0]  hex;
   logic [8:0]  esc;
   logic        is_ux;
   logic [2:0]  digits_dec;
   logic [15:0] accum_shift;
   logic        fail;

   assign c           = req_data.in_byte;
   assign last        = req_data.literal_end;
   assign hex         = hex_digit(c);
   assign esc         = simple_escape(c);
   assign is_ux       = (c == CHAR_U) || (c == CHAR_X);
   assign digits_dec  = digits_ff - 3'd1;
   assign accum_shift = {accum_ff[11:0], hex[3:0]};

   always_comb begin
      fail = 1'b0;
      unique case (mode_ff)
         MODE_PLAIN: fail = (c == CHAR_BACKSLASH) && last;
         MODE_ESC:   fail = is_ux ? last : !esc[8];
         MODE_HEX:   fail = !hex[4] || ((digits_dec != 3'd0) && last);
         MODE_DROP:  fail = 1'b0;
         default:    fail = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      accum_in  = accum_ff;
      if (fail) begin
         mode_in   = last ? MODE_PLAIN : MODE_DROP;
         digits_in = 3'd0;
         accum_in  = 16'd0;
      end else begin
         unique case (mode_ff)
            MODE_PLAIN: begin
               if (c == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               if (is_ux) begin
                  mode_in   = MODE_HEX;
                  digits_in = (c == CHAR_U) ? DIGITS_U : DIGITS_X;
                  accum_in  = 16'd0;
               end else begin
                  mode_in = MODE_PLAIN;
               end
            end
            MODE_HEX: begin
               digits_in = digits_dec;
               if (digits_dec != 3'd0) begin
                  accum_in = accum_shift;
               end else begin
                  mode_in  = MODE_PLAIN;
                  accum_in = 16'd0;
               end
            end
            MODE_DROP: begin
               if (last) begin
                  mode_in   = MODE_PLAIN;
                  digits_in = 3'd0;
                  accum_in  = 16'd0;
               end
            end
            default: mode_in = MODE_PLAIN;
         endcase
      end
   end

   // result record
   always_comb begin
      rec = '0;
      if (fail) begin
         rec = error_rec();
      end else begin
         unique case (mode_ff)
            MODE_PLAIN: begin
               if (c != CHAR_BACKSLASH) begin
                  rec = single_rec(c, last);
               end
            end
            MODE_ESC: begin
               if (!is_ux) begin
                  rec = single_rec(esc[7:0], last);
               end
            end
            MODE_HEX: begin
               if (digits_dec == 3'd0) begin
                  rec = utf8_rec(accum_shift, last);
               end
            end
            MODE_DROP: rec = '0;
            default:   rec = '0;
         endcase
      end
   end

   assign rec_valid = accept && (rec.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         digits_ff <= 3'd0;
         accum_ff  <= 16'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         accum_ff  <= accum_in;
      end
   end

endmodule

// ===== src/esu8_queue.sv =====
// short record queue between decoder front end and byte serializer
// depends on esu8_pkg
module esu8_queue #(
   parameter int Depth = esu8_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  esu8_pkg::record_type push_data,
   output logic                 full,
   input  logic                 pop,
   output esu8_pkg::record_type head,
   output logic                 empty
);
   import esu8_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   record_type          mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/esu8_back.sv =====
// back end: walks each record one byte per cycle into the result register while that register is free
// depends on esu8_pkg
module esu8_back (
   input  logic                 clock,
   input  logic                 reset,
   input  esu8_pkg::record_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output esu8_pkg::rsp_type    rsp_data,
   output logic                 empty,
   input  logic                 pop
);
   import esu8_pkg::*;

   logic [1:0] idx_ff, idx_in;
   rsp_type    rsp_ff, rsp_in;
   logic       valid_ff, valid_in;
   logic       load;
   logic       final_byte;

   // output register is free when empty or taken this cycle
   assign load       = !valid_ff || pop;
   assign final_byte = (idx_ff == head.count - 2'd1);
   assign q_pop      = load && !q_empty && final_byte;

   always_comb begin
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            rsp_in.out_byte   = head.bytes[idx_ff];
            rsp_in.out_last   = head.last && final_byte;
            rsp_in.bad_escape = head.bad;
            idx_in            = final_byte ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_data = rsp_ff;
   assign empty    = !valid_ff;

endmodule

// ===== src/escape_sequence_to_utf8_top.sv =====
// escape sequence to utf-8 decoder, top level
// depends on esu8_pkg, esu8_front, esu8_queue, esu8_back
//
// Input side is a queue write port: one raw byte of a string literal body per
// transfer (push while full is low), literal_end set on the final byte.
// Result side is a queue read port: while empty is low, rsp_data holds the
// oldest decoded utf-8 byte; pop while empty is low takes it.
// An input byte is decoded in the cycle it is taken, its results (one to
// three bytes, if any) go as one record into a QueueDepth-entry record
// queue, and a serializer moves one byte per cycle into the result register
// while that register is free: a result passes the record queue, then the
// result register. Input throughput is one byte per cycle while full is low;
// results go out one byte per cycle while popped, so a three-byte \u escape
// holds the serializer for all its bytes; full rises only when the record queue fills.
// A bad or unfinished escape gives a single result with bad_escape and
// out_last set and out_byte zero; later bytes up to literal_end give nothing.
// Synchronous reset empties the queue and result register and returns the
// decoder to plain-byte mode. When the receiver stalls, the result holds and
// the queue backs up into full.
module escape_sequence_to_utf8_top #(
   parameter int QueueDepth = esu8_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  esu8_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output esu8_pkg::rsp_type rsp_data
);
   import esu8_pkg::*;

   logic       accept;
   logic       rec_valid;
   record_type rec;
   record_type head;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   esu8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   esu8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_data (rec),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty)
   );

   esu8_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

endmodule

// ===== src/esu8_checker.sv =====
// port-level checker for the escape decoder, bound to the top level
// depends on esu8_pkg and escape_sequence_to_utf8_top_assert.svh
`include "escape_sequence_to_utf8_top_assert.svh"

module esu8_checker (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input esu8_pkg::req_type req_data,
   input logic              empty,
   input logic              pop,
   input esu8_pkg::rsp_type rsp_data
);
   import esu8_pkg::*;

   logic bad_shown;
   logic error_ok;
   logic stalled;

   assign bad_shown = !empty && rsp_data.bad_escape;
   assign error_ok  = rsp_data.out_last && (rsp_data.out_byte == 8'd0);
   assign stalled   = !empty && !pop;

   `ESU8_CHECK_ALWAYS(a_reset_empty, clock, reset |=> empty, "results present after reset")

   `ESU8_CHECK_ALWAYS(a_reset_not_full, clock, reset |=> !full, "full after reset")

   `ESU8_CHECK(a_error_form, clock, reset, bad_shown |-> error_ok, "malformed error result")

   `ESU8_CHECK(a_stall_hold, clock, reset, stalled |=> !empty && $stable(rsp_data), "result not held")

endmodule

bind escape_sequence_to_utf8_top esu8_checker u_esu8_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

// ===== verif/escape_sequence_to_utf8_top_tb.sv =====
// testbench for the escape sequence to utf-8 decoder top level
// needs esu8_pkg and escape_sequence_to_utf8_top; holds its own decode predictor,
// a burst sender, a stalling receiver and an in-order result checker
module escape_sequence_to_utf8_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import esu8_pkg::*;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   escape_sequence_to_utf8_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

   // decoder state as the predictor sees it
   mode_type    pred_mode;
   logic [2:0]  pred_digits;
   logic [15:0] pred_code;

   rsp_type     expected_bytes[$];
   int          mismatch_count;
   int          items_sent;
   int          burst_left;
   bit          sender_no_gaps;
   int          rx_hold_request;

   logic [7:0]  escape_letters[11] = '{CHAR_BACKSLASH, CHAR_QUOTE, CHAR_DQUOTE, CHAR_A,
                                       CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T, CHAR_V,
                                       CHAR_ZERO};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("escape_sequence_to_utf8_top regression: fail");
      $finish;
   end

   // ---------------- predictor ----------------

   task automatic expect_byte(input logic [7:0] b, input logic last, input logic bad);
      rsp_type r;
      r.out_byte   = b;
      r.out_last   = last;
      r.bad_escape = bad;
      expected_bytes.push_back(r);
   endtask

   task automatic expect_reject(input logic e);
      pred_mode   = e ? MODE_PLAIN : MODE_DROP;
      pred_digits = '0;
      pred_code   = '0;
      expect_byte(8'h00, 1'b1, 1'b1);
   endtask

   task automatic predict_decode(input logic [7:0] c, input logic e);
      logic       is_hex;
      logic [3:0] nib;
      logic       known;
      logic [7:0] code;
      is_hex = 1'b1;
      nib    = '0;
      known  = 1'b1;
      code   = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) nib = 4'(c - CHAR_ZERO);
      else if (c >= CHAR_A && c <= CHAR_F) nib = 4'(c - CHAR_A + 8'd10);
      else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) nib = 4'(c - CHAR_UPPER_A + 8'd10);
      else is_hex = 1'b0;
      case (pred_mode)
         MODE_PLAIN: begin
            if (c == CHAR_BACKSLASH) begin
               if (e) expect_reject(e);
               else pred_mode = MODE_ESC;
            end else begin
               expect_byte(c, e, 1'b0);
            end
         end
         MODE_ESC: begin
            if (c == CHAR_U || c == CHAR_X) begin
               if (e) begin
                  expect_reject(e);
               end else begin
                  pred_mode   = MODE_HEX;
                  pred_digits = (c == CHAR_U) ? DIGITS_U : DIGITS_X;
                  pred_code   = '0;
               end
            end else begin
               case (c)
                  CHAR_BACKSLASH: code = CHAR_BACKSLASH;
                  CHAR_QUOTE:     code = CHAR_QUOTE;
                  CHAR_DQUOTE:    code = CHAR_DQUOTE;
                  CHAR_A:         code = CODE_BEL;
                  CHAR_B:         code = CODE_BS;
                  CHAR_F:         code = CODE_FF;
                  CHAR_N:         code = CODE_LF;
                  CHAR_R:         code = CODE_CR;
                  CHAR_T:         code = CODE_TAB;
                  CHAR_V:         code = CODE_VT;
                  CHAR_ZERO:      code = CODE_NUL;
                  default:        known = 1'b0;
               endcase
               if (!known) begin
                  expect_reject(e);
               end else begin
                  pred_mode = MODE_PLAIN;
                  expect_byte(code, e, 1'b0);
               end
            end
         end
         MODE_HEX: begin
            if (!is_hex) begin
               expect_reject(e);
            end else begin
               pred_code   = {pred_code[11:0], nib};
               pred_digits = pred_digits - 3'd1;
               if (pred_digits != 3'd0) begin
                  if (e) expect_reject(e);
               end else begin
                  pred_mode = MODE_PLAIN;
                  if (pred_code <= 16'h007F) begin
                     expect_byte(pred_code[7:0], e, 1'b0);
                  end else if (pred_code <= 16'h07FF) begin
                     expect_byte({3'b110, pred_code[10:6]}, 1'b0, 1'b0);
                     expect_byte({2'b10, pred_code[5:0]}, e, 1'b0);
                  end else begin
                     expect_byte({4'b1110, pred_code[15:12]}, 1'b0, 1'b0);
                     expect_byte({2'b10, pred_code[11:6]}, 1'b0, 1'b0);
                     expect_byte({2'b10, pred_code[5:0]}, e, 1'b0);
                  end
                  pred_code = '0;
               end
            end
         end
         default: begin
            // dropping the rest of a rejected literal
            if (e) begin
               pred_mode   = MODE_PLAIN;
               pred_digits = '0;
               pred_code   = '0;
            end
         end
      endcase
   endtask

   // ---------------- sender ----------------

   task automatic send_byte(input logic [7:0] b, input logic e);
      int gap;
      req_data <= '{in_byte: b, literal_end: e};
      push     <= 1'b1;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      predict_decode(b, e);
      items_sent++;
      if (sender_no_gaps) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 12);
      end
   endtask

   task automatic send_literal(input logic [7:0] lit[$]);
      foreach (lit[i]) send_byte(lit[i], i == lit.size() - 1);
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      do begin
         @(posedge clock);
         n++;
      end while (expected_bytes.size() != 0 && n < 20000);
   endtask

   task automatic pause_until_drained();
      push <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return CHAR_ZERO + 8'(v);
      if ($urandom_range(0, 1)) return CHAR_A + 8'(v) - 8'd10;
      return CHAR_UPPER_A + 8'(v) - 8'd10;
   endfunction

   function automatic bit letter_is_escape(input logic [7:0] c);
      if (c == CHAR_U || c == CHAR_X) return 1'b1;
      foreach (escape_letters[i]) if (escape_letters[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit char_is_hex(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || (c >= CHAR_A && c <= CHAR_F)
             || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F);
   endfunction

   task automatic build_random_literal(output logic [7:0] lit[$]);
      int         nseg;
      int         kind;
      int         ndig;
      logic [7:0] b;
      logic [15:0] cp;
      lit  = {};
      nseg = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
         // noise: raw bytes with plenty of backslashes
         repeat ($urandom_range(1, 8))
            lit.push_back($urandom_range(0, 2) == 0 ? CHAR_BACKSLASH
                                                    : 8'($urandom_range(0, 255)));
         return;
      end
      repeat (nseg) begin
         kind = $urandom_range(0, 99);
         if (kind < 28) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHAR_BACKSLASH);
            lit.push_back(b);
         end else if (kind < 48) begin
            lit.push_back(CHAR_BACKSLASH);
            lit.push_back(escape_letters[$urandom_range(0, 10)]);
         end else if (kind < 62) begin
            lit.push_back(CHAR_BACKSLASH);
            lit.push_back(CHAR_X);
            b = 8'($urandom_range(0, 255));
            lit.push_back(hex_char(b[7:4]));
            lit.push_back(hex_char(b[3:0]));
         end else if (kind < 82) begin
            case ($urandom_range(0, 2))
               0:       cp = 16'($urandom_range(0, 'h7F));
               1:       cp = 16'($urandom_range('h80, 'h7FF));
               default: cp = 16'($urandom_range('h800, 'hFFFF));
            endcase
            lit.push_back(CHAR_BACKSLASH);
            lit.push_back(CHAR_U);
            for (int i = 3; i >= 0; i--) lit.push_back(hex_char(cp[i*4 +: 4]));
         end else if (kind < 90) begin
            // unknown escape letter
            do b = 8'($urandom_range(0, 255)); while (letter_is_escape(b));
            lit.push_back(CHAR_BACKSLASH);
            lit.push_back(b);
         end else begin
            // bad digit inside a hex escape
            lit.push_back(CHAR_BACKSLASH);
            ndig = $urandom_range(0, 1) ? 2 : 4;
            lit.push_back(ndig == 2 ? CHAR_X : CHAR_U);
            repeat ($urandom_range(0, ndig - 1))
               lit.push_back(hex_char(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255)); while (char_is_hex(b));
            lit.push_back(b);
         end
      end
      // cut some literals short so escapes end at the last byte
      if ($urandom_range(0, 9) == 0) while (lit.size() > 1 && $urandom_range(0, 2) != 0)
         void'(lit.pop_back());
   endtask

   // ---------------- tests ----------------

   task automatic test_plain_extremes();
      send_literal('{8'h00});
      send_literal('{8'hFF, 8'h41, 8'h00, 8'h7F});
   endtask

   task automatic test_simple_escapes();
      send_literal('{CHAR_BACKSLASH, CHAR_N, CHAR_BACKSLASH, CHAR_ZERO,
                     CHAR_BACKSLASH, CHAR_BACKSLASH});
   endtask

   task automatic test_hex_escapes();
      // zero code point, then the largest code points of each form at the end byte
      send_literal('{CHAR_BACKSLASH, CHAR_X, CHAR_ZERO, CHAR_ZERO,
                     CHAR_BACKSLASH, CHAR_X, CHAR_UPPER_F, CHAR_F});
      send_literal('{CHAR_BACKSLASH, CHAR_U, CHAR_F, CHAR_UPPER_F, CHAR_F, CHAR_UPPER_F});
   endtask

   task automatic test_rejects();
      // trailing backslash
      send_literal('{CHAR_BACKSLASH});
      // literal ends right after the escape letter
      send_literal('{CHAR_BACKSLASH, CHAR_U});
      // too few digits
      send_literal('{CHAR_BACKSLASH, CHAR_X, CHAR_NINE});
      // unknown letter, rest dropped
      send_literal('{CHAR_BACKSLASH, 8'h71, CHAR_A, CHAR_BACKSLASH});
      // non-hex digit, rest dropped
      send_literal('{CHAR_BACKSLASH, CHAR_U, CHAR_ZERO, 8'h67, 8'hFF});
   endtask

   task automatic test_random_literals();
      logic [7:0] lit[$];
      int         stop_at;
      stop_at = items_sent + 124;
      while (items_sent < stop_at) begin
         build_random_literal(lit);
         send_literal(lit);
      end
   endtask

   task automatic test_receiver_hold();
      logic [7:0] lit[$];
      rx_hold_request = 150;
      sender_no_gaps  = 1'b1;
      repeat (6) begin
         lit = '{CHAR_BACKSLASH, CHAR_U, CHAR_UPPER_A, hex_char(4'($urandom_range(0, 15))),
                 hex_char(4'($urandom_range(0, 15))), hex_char(4'($urandom_range(0, 15)))};
         send_literal(lit);
      end
      sender_no_gaps = 1'b0;
   endtask

   // ---------------- receiver ----------------

   initial begin
      int hold;
      int pattern;
      int tick;
      hold    = 0;
      pattern = 0;
      tick    = 0;
      pop     = 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 64 == 0) pattern = $urandom_range(0, 3);
         if (rx_hold_request > 0) begin
            hold            = rx_hold_request;
            rx_hold_request = 0;
         end
         if (hold > 0) begin
            hold--;
            pop <= 1'b0;
         end else begin
            case (pattern)
               0:       pop <= 1'b1;
               1:       pop <= $urandom_range(0, 1);
               2:       pop <= (tick % 5) < 2;
               default: pop <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // every accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_bytes.size() == 0) begin
            $error("result transfer with nothing expected: out_byte %h", rsp_data.out_byte);
            mismatch_count++;
         end else begin
            want = expected_bytes[0];
            expected_bytes.delete(0);
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte expected %h actual %h", want.out_byte, rsp_data.out_byte);
               mismatch_count++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $error("out_last expected %b actual %b", want.out_last, rsp_data.out_last);
               mismatch_count++;
            end
            if (rsp_data.bad_escape !== want.bad_escape) begin
               $error("bad_escape expected %b actual %b", want.bad_escape, rsp_data.bad_escape);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      reset           = 1'b1;
      push            = 1'b0;
      req_data        = '0;
      mismatch_count  = 0;
      items_sent      = 0;
      burst_left      = 0;
      sender_no_gaps  = 1'b0;
      rx_hold_request = 0;
      pred_mode       = MODE_PLAIN;
      pred_digits     = '0;
      pred_code       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_extremes();
      test_simple_escapes();
      test_hex_escapes();
      test_rejects();
      pause_until_drained();
      test_receiver_hold();
      pause_until_drained();
      test_random_literals();

      push <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("%0d expected results never arrived", expected_bytes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("escape_sequence_to_utf8_top regression: pass");
      end else begin
         $display("escape_sequence_to_utf8_top regression: fail");
      end
      $finish;
   end

endmodule
